### sv/mbfh_pkg.sv
// shared constants, codes and the crc-16 step for the modbus-style frame handler
// no dependencies; used by the channel interfaces and the top level
package mbfh_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;
	typedef logic [1:0]  kind_t;
	typedef logic [1:0]  trans_t;

	localparam int FRAME_LEN = 8;
	localparam int IDX_W     = $clog2(FRAME_LEN);

	localparam byte_t DEVICE_ID_RESET = 8'd1;

	// function codes
	localparam byte_t FN_PREOP     = 8'd80;
	localparam byte_t FN_RESET     = 8'd81;
	localparam byte_t FN_STOP      = 8'd2;
	localparam byte_t FN_READ      = 8'd1;
	localparam byte_t FN_WRITE_REG = 8'd6;
	localparam byte_t EXC_OFFSET   = 8'd80;

	// exception codes
	localparam byte_t EXC_ILLEGAL_FUNC = 8'd1;
	localparam byte_t EXC_ILLEGAL_ADDR = 8'd2;
	localparam byte_t EXC_ILLEGAL_DATA = 8'd3;

	// result kinds
	localparam kind_t KIND_BYTE  = 2'd0;
	localparam kind_t KIND_STATE = 2'd1;
	localparam kind_t KIND_REF   = 2'd2;

	// state change codes
	localparam trans_t TR_PREOP = 2'd0;
	localparam trans_t TR_RESET = 2'd1;
	localparam trans_t TR_STOP  = 2'd2;

	localparam word_t CRC_INIT = 16'hFFFF;
	localparam word_t CRC_POLY = 16'hA001;

	// one byte of crc-16/modbus, lsb first
	function automatic word_t crc_step(input word_t crc, input byte_t b);
		word_t c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### sv/mbfh_in_if.sv
// receive channel: one frame byte plus the current measured speed per transfer
// depends on mbfh_pkg
interface mbfh_in_if;
	import mbfh_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;
	word_t measured_speed;

	modport source (output valid, output rx_byte, output measured_speed, input ready);
	modport sink (input valid, input rx_byte, input measured_speed, output ready);
endinterface

### sv/mbfh_out_if.sv
// result channel: response bytes, state change requests and reference updates
// depends on mbfh_pkg
interface mbfh_out_if;
	import mbfh_pkg::*;

	logic   valid;
	logic   ready;
	kind_t  kind;
	byte_t  tx_byte;
	logic   last;
	trans_t transition_code;
	word_t  speed_reference;

	modport source (output valid, output kind, output tx_byte, output last,
		output transition_code, output speed_reference, input ready);
	modport sink (input valid, input kind, input tx_byte, input last,
		input transition_code, input speed_reference, output ready);
endinterface

### sv/modbus_style_frame_handler.sv
// Modbus-RTU-style slave frame handler. Bytes are stored one per transfer in an
// 8-entry frame memory; a byte that does not complete the frame leaves the input open.
// The eighth byte starts a read pass over the memory's single read port (seven
// registered reads), during which the crc-16/modbus unit folds in one byte per cycle;
// a wait state and a judge state then decide the frame. Results leave one per
// cycle while the sink is ready: none, one state change request, or an 8-byte response
// (preceded by a reference update for a register write). No input is taken from the
// read pass until all results are issued; a result still waiting in the output
// register does not block the next byte.
// depends on mbfh_pkg, mbfh_in_if, mbfh_out_if
module modbus_style_frame_handler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  mbfh_pkg::byte_t cfg_wdata,
	mbfh_in_if.sink        in_ch,
	mbfh_out_if.source     out_ch
);
	import mbfh_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_WAIT,
		S_JUDGE,
		S_NOTE,
		S_FRAME
	} state_t;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0] CRC_HI_IDX = IDX_W'(FRAME_LEN - 2);

	state_t           state_q;
	logic [IDX_W-1:0] byte_cnt_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic             pend_q;
	logic [IDX_W-1:0] tx_idx_q;
	byte_t            device_id_q;
	byte_t            byte7_q;
	word_t            speed_q;
	word_t            crc_q;
	byte_t            resp_func_q;
	byte_t            resp_hi_q;
	byte_t            resp_lo_q;
	kind_t            note_kind_q;
	trans_t           note_code_q;
	word_t            note_sref_q;

	logic             out_valid_q;
	kind_t            out_kind_q;
	byte_t            out_byte_q;
	logic             out_last_q;
	trans_t           out_code_q;
	word_t            out_sref_q;

	byte_t            frame_mem [0:FRAME_LEN-1];
	byte_t            rdata_q;
	byte_t            fb_q [0:FRAME_LEN-2];

	logic             in_xfer;
	logic             out_free;
	logic             addr_ok;
	logic             reg_zero;
	logic             reg_one;
	logic             crc_ok;
	byte_t            frame_byte;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign addr_ok  = (fb_q[0] == device_id_q);
	assign reg_zero = (fb_q[2] == 8'd0) && (fb_q[3] == 8'd0);
	assign reg_one  = (fb_q[2] == 8'd0) && (fb_q[3] == 8'd1);
	assign crc_ok   = ({fb_q[6], byte7_q} == crc_q);

	always_comb begin
		case (tx_idx_q)
			3'd0: frame_byte = fb_q[0];
			3'd1: frame_byte = resp_func_q;
			3'd2: frame_byte = fb_q[2];
			3'd3: frame_byte = fb_q[3];
			3'd4: frame_byte = resp_hi_q;
			3'd5: frame_byte = resp_lo_q;
			3'd6: frame_byte = crc_q[15:8];
			default: frame_byte = crc_q[7:0];
		endcase
	end

	// frame store: written only while idle; its read data is used only during the read pass
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			frame_mem[byte_cnt_q] <= in_ch.rx_byte;
		end
		rdata_q <= frame_mem[rd_idx_q];
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			fb_q[pend_idx_q] <= rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			byte_cnt_q  <= '0;
			rd_idx_q    <= '0;
			pend_idx_q  <= '0;
			pend_q      <= 1'b0;
			tx_idx_q    <= '0;
			device_id_q <= DEVICE_ID_RESET;
			byte7_q     <= '0;
			speed_q     <= '0;
			crc_q       <= CRC_INIT;
			resp_func_q <= '0;
			resp_hi_q   <= '0;
			resp_lo_q   <= '0;
			note_kind_q <= KIND_BYTE;
			note_code_q <= TR_PREOP;
			note_sref_q <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_BYTE;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_code_q  <= TR_PREOP;
			out_sref_q  <= '0;
		end else begin
			if (cfg_we) begin
				device_id_q <= cfg_wdata;
			end
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			pend_q <= 1'b0;
			// read data is registered and returns in the cycle after its address; crc covers bytes 0..5
			if (pend_q && (pend_idx_q != CRC_HI_IDX)) begin
				crc_q <= crc_step(crc_q, rdata_q);
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (byte_cnt_q == LAST_IDX) begin
							byte_cnt_q <= '0;
							byte7_q    <= in_ch.rx_byte;
							speed_q    <= in_ch.measured_speed;
							crc_q      <= CRC_INIT;
							rd_idx_q   <= '0;
							state_q    <= S_READ;
						end else begin
							byte_cnt_q <= byte_cnt_q + 1'b1;
						end
					end
				end
				S_READ: begin
					pend_q     <= 1'b1;
					pend_idx_q <= rd_idx_q;
					if (rd_idx_q == CRC_HI_IDX) begin
						state_q <= S_WAIT;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				S_WAIT: begin
					state_q <= S_JUDGE;
				end
				S_JUDGE: begin
					crc_q       <= CRC_INIT;
					tx_idx_q    <= '0;
					resp_func_q <= fb_q[1] + EXC_OFFSET;
					resp_hi_q   <= '0;
					note_sref_q <= {fb_q[4], fb_q[5]};
					if (!addr_ok) begin
						state_q <= S_IDLE;
					end else if (reg_zero) begin
						note_kind_q <= KIND_STATE;
						if (!crc_ok) begin
							state_q <= S_IDLE;
						end else if (fb_q[1] == FN_PREOP) begin
							note_code_q <= TR_PREOP;
							state_q     <= S_NOTE;
						end else if (fb_q[1] == FN_RESET) begin
							note_code_q <= TR_RESET;
							state_q     <= S_NOTE;
						end else if (fb_q[1] == FN_STOP) begin
							note_code_q <= TR_STOP;
							state_q     <= S_NOTE;
						end else if (fb_q[1] == FN_READ) begin
							resp_lo_q <= EXC_ILLEGAL_DATA;
							state_q   <= S_FRAME;
						end else begin
							resp_lo_q <= EXC_ILLEGAL_FUNC;
							state_q   <= S_FRAME;
						end
					end else if (reg_one) begin
						// write reply echoes the frame with the measured speed as data
						note_kind_q <= KIND_REF;
						note_code_q <= TR_PREOP;
						resp_func_q <= fb_q[1];
						resp_hi_q   <= speed_q[15:8];
						resp_lo_q   <= speed_q[7:0];
						if ((fb_q[1] == FN_WRITE_REG) && crc_ok) begin
							state_q <= S_NOTE;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						resp_lo_q <= EXC_ILLEGAL_ADDR;
						state_q   <= S_FRAME;
					end
				end
				S_NOTE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= note_kind_q;
						out_byte_q  <= '0;
						if (note_kind_q == KIND_STATE) begin
							out_last_q <= 1'b1;
							out_code_q <= note_code_q;
							out_sref_q <= '0;
							state_q    <= S_IDLE;
						end else begin
							out_last_q <= 1'b0;
							out_code_q <= TR_PREOP;
							out_sref_q <= note_sref_q;
							state_q    <= S_FRAME;
						end
					end
				end
				S_FRAME: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_BYTE;
						out_byte_q  <= frame_byte;
						out_last_q  <= (tx_idx_q == LAST_IDX);
						out_code_q  <= TR_PREOP;
						out_sref_q  <= '0;
						// fresh crc built from the bytes as they go out, high byte first
						if (tx_idx_q < CRC_HI_IDX) begin
							crc_q <= crc_step(crc_q, frame_byte);
						end
						if (tx_idx_q == LAST_IDX) begin
							state_q <= S_IDLE;
						end else begin
							tx_idx_q <= tx_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.kind            = out_kind_q;
	assign out_ch.tx_byte         = out_byte_q;
	assign out_ch.last            = out_last_q;
	assign out_ch.transition_code = out_code_q;
	assign out_ch.speed_reference = out_sref_q;

	// the frame counter only moves while bytes are taken
	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (byte_cnt_q == '0))
		else $error("frame byte count moved outside idle");

	// a completed frame closes the input until it has been handled
	a_frame_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (byte_cnt_q == LAST_IDX)) |=> !in_ch.ready)
		else $error("input open right after the eighth byte");

	// a state change request is always the only result of its frame
	a_state_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.kind == KIND_STATE)) |-> out_ch.last)
		else $error("state change request not marked last");

	// a reference update is always followed by its echo frame
	a_ref_then_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.kind == KIND_REF)) |-> (!out_ch.last && (state_q == S_FRAME)))
		else $error("reference update without a following reply");

endmodule
